// ----- rtl/core/lcmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lcmd_pkg
// Shared widths, codes and controller/datapath interface types of the
// lane change maneuver debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcmd_pkg;

  localparam int unsigned TRACK_W     = 4;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned VEL_W       = 16;
  localparam int unsigned MAN_W       = 2;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned RUN_W       = 5;
  localparam int unsigned MS_W        = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 5'd31;
  localparam logic [MS_W-1:0]   MS_PER_S  = 10'd1000;
  localparam logic [DIST_W-1:0] DIST_RST  = 16'd1000;
  localparam logic [DIST_W-1:0] TIME_RST  = 16'd5000;
  localparam logic [RUN_W-1:0]  RUN_RST   = 5'd3;

  typedef enum logic [MAN_W-1:0] {
    MAN_FOLLOW = 2'd0,
    MAN_LEFT   = 2'd1,
    MAN_RIGHT  = 2'd2
  } maneuver_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST = 2'd0,
    REG_TIME = 2'd1,
    REG_RUN  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic update;
  } lcmd_cmd_t;

  typedef struct packed {
    logic out_free;
  } lcmd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/lcmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcmd_ctrl
// Two-state controller: takes an item, then runs the slot update once the
// output register can take the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lcmd_ctrl
  import lcmd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  lcmd_stat_t      stat_i,
  output lcmd_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPD;
        end
      end
      ST_UPD: begin
        if (stat_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lcmd_dpath.sv -----
// ----------------------------------------------------------------------------
// lcmd_dpath
// Datapath: configuration registers, raw guess, per-slot state memory with
// valid bits, debounce check and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcmd_dpath
  import lcmd_pkg::*;
#(
  parameter int unsigned TRACKS  = 16,
  parameter int unsigned MAX_RUN = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  lcmd_cmd_t                   cmd_i,
  output lcmd_stat_t                  stat_o,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic [IN_TUSER_W-1:0]  s_tuser_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_tdata_o
);

  localparam int unsigned SLOT_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned HIST_W  = 2 * MAX_RUN;
  localparam int unsigned ENTRY_W = HIST_W + CNT_W + MAN_W;
  localparam int unsigned CMP_W   = CNT_W + 1;
  localparam int unsigned NUM_IDS = 2 ** TRACK_W;
  localparam int unsigned PROD_W  = DIST_W + VEL_W + 1;

  // configuration
  logic [DIST_W-1:0] dist_q, time_q;
  logic [RUN_W-1:0]  run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= DIST_RST;
      time_q <= TIME_RST;
      run_q  <= RUN_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_DIST: dist_q <= cfg_wdata_i;
        REG_TIME: time_q <= cfg_wdata_i;
        REG_RUN:  run_q  <= cfg_wdata_i[RUN_W-1:0];
        default:  ;
      endcase
    end
  end

  // input fields
  logic [TRACK_W-1:0]       track_in;
  logic [DIST_W-1:0]        ld_in, rd_in;
  logic signed [VEL_W-1:0]  lv_in, rv_in;
  logic                     new_in, found_in;

  assign track_in = s_tdata_i[3:0];
  assign ld_in    = s_tdata_i[19:4];
  assign rd_in    = s_tdata_i[35:20];
  assign lv_in    = s_tdata_i[51:36];
  assign rv_in    = s_tdata_i[67:52];
  assign new_in   = s_tuser_i[0];
  assign found_in = s_tuser_i[1];

  // track id to slot
  logic [SLOT_W-1:0] slot_lut [NUM_IDS];
  logic [SLOT_W-1:0] slot_in;

  for (genvar v = 0; v < NUM_IDS; v++) begin : g_slot
    localparam int unsigned SlotV = v % TRACKS;
    assign slot_lut[v] = SLOT_W'(SlotV);
  end

  assign slot_in = slot_lut[track_in];

  // raw guess on the nearer bound
  logic                    left_side, near;
  logic [DIST_W-1:0]       d_sel;
  logic signed [VEL_W-1:0] v_sel;
  logic [VEL_W:0]          v_ext, v_abs;
  logic [DIST_W+MS_W-1:0]  lhs;
  logic [PROD_W-1:0]       rhs;
  logic [MAN_W-1:0]        cand_d, cand_q;

  assign left_side = ld_in < rd_in;
  assign d_sel     = left_side ? ld_in : rd_in;
  assign v_sel     = left_side ? lv_in : rv_in;
  assign v_ext     = {v_sel[VEL_W-1], v_sel};
  assign v_abs     = v_sel[VEL_W-1] ? (~v_ext + (VEL_W+1)'(1)) : v_ext;
  assign lhs       = d_sel * MS_PER_S;
  assign rhs       = time_q * v_abs;
  assign near      = (ld_in != rd_in) && (d_sel < dist_q) && v_sel[VEL_W-1]
                     && (PROD_W'(lhs) < rhs);
  assign cand_d    = (found_in && ((ld_in | rd_in) != '0) && near)
                     ? (left_side ? MAN_LEFT : MAN_RIGHT) : MAN_FOLLOW;

  // slot state memory: {history, frame count, last output}
  logic [ENTRY_W-1:0] mem_q [TRACKS];
  logic [TRACKS-1:0]  valid_q;
  logic [ENTRY_W-1:0] rd_entry_q, entry_new;
  logic               vld_q, new_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TRACK_W-1:0] track_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem_q[slot_q] <= entry_new;
    end
    if (cmd_i.load) begin
      rd_entry_q <= mem_q[slot_in];
      vld_q      <= valid_q[slot_in];
      slot_q     <= slot_in;
      track_q    <= track_in;
      new_q      <= new_in;
      cand_q     <= cand_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.update) begin
      valid_q[slot_q] <= 1'b1;
    end
  end

  // debounce
  logic                keep, first, agree;
  logic [HIST_W-1:0]   hist_old, hist_new;
  logic [HIST_W+1:0]   hist_sh;
  logic [CNT_W-1:0]    fc_old, fc_new;
  logic [MAN_W-1:0]    last_old, raw, outm;

  assign keep     = vld_q & ~new_q;
  assign hist_old = keep ? rd_entry_q[ENTRY_W-1 -: HIST_W] : '0;
  assign fc_old   = keep ? rd_entry_q[MAN_W +: CNT_W] : '0;
  assign last_old = keep ? rd_entry_q[MAN_W-1:0] : MAN_FOLLOW;
  assign fc_new   = (fc_old < COUNT_MAX) ? fc_old + CNT_W'(1) : COUNT_MAX;
  assign first    = fc_new < CNT_W'(2);
  assign raw      = first ? MAN_FOLLOW : cand_q;
  assign hist_sh  = {hist_old, raw};
  assign hist_new = hist_sh[HIST_W-1:0];

  always_comb begin
    agree = 1'b1;
    for (int i = 0; i < MAX_RUN; i++) begin
      if ((CMP_W'(i) < {1'b0, run_q}) && (CMP_W'(i) < {1'b0, fc_new})
          && (hist_new[2*i +: 2] != raw)) begin
        agree = 1'b0;
      end
    end
  end

  assign outm      = (first || agree) ? raw : last_old;
  assign entry_new = {hist_new, fc_new, outm};

  // output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      m_data_q <= {outm, raw, track_q};
    end
  end

  assign stat_o.out_free = ~m_valid_q | m_tready_i;
  assign m_tvalid_o      = m_valid_q;
  assign m_tdata_o       = m_data_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (!m_valid_q || m_tready_i))
    else $error("result overwritten before it was taken");

  a_load_update_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.update))
    else $error("load and update in the same cycle");

  a_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> valid_q[$past(slot_q)])
    else $error("updated slot not marked valid");

  a_out_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[7:6] != 2'b11) && (m_data_q[5:4] != 2'b11))
    else $error("maneuver code out of range");

endmodule

`default_nettype wire

// ----- rtl/core/lane_change_maneuver_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// lane_change_maneuver_debouncer_top
// Per-track lane change guess with run-length debounce.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one object frame per item; m_axis returns one result item
//   per input item, in order. Configuration registers (distance threshold,
//   time threshold, run length) are written through cfg_we_i / cfg_addr_i /
//   cfg_wdata_i while no item is in flight.
//   When an item is taken, the slot state is read from the state memory
//   into a register; the update state then checks the history, writes the
//   slot back and loads the output register once that register is free.
//   The controller takes no new item until the update of the last one is
//   done, since it reads, modifies and writes back one slot per item.
//   If the receiver stalls, the result waits in the output register; one
//   more item is taken and then held until the output register frees up.
//   Reset clears the configuration to its defaults and marks every slot
//   empty (valid bits), so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_change_maneuver_debouncer_top
  import lcmd_pkg::*;
#(
  parameter int unsigned TRACKS  = 16,
  parameter int unsigned MAX_RUN = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // track_index[3:0], left_dist_mm[19:4], right_dist_mm[35:20],
  // left_vel_mm_s[51:36], right_vel_mm_s[67:52], zero fill [71:68]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // new_track[0], lanelet_found[1]
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // result_track[3:0], raw_maneuver[5:4], maneuver[7:6]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  lcmd_cmd_t  cmd;
  lcmd_stat_t stat;

  lcmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcmd_dpath #(
    .TRACKS  (TRACKS),
    .MAX_RUN (MAX_RUN)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ----- tb/lane_change_maneuver_debouncer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_change_maneuver_debouncer_top_test
// Self-checking bench for the per-track lane change debouncer. Frames go in
// on the input stream with random gaps and the results come back under
// random backpressure. Each frame is run through a local model of the raw
// guess and the run-length debounce, and every result is checked against it
// in order. Directed frames cover the first-frame, missing-lane, zero-width,
// equal-distance and time-boundary cases, then traffic runs under several
// threshold and run-length settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_change_maneuver_debouncer_top_test;
  import lcmd_pkg::*;

  localparam int SLOTS = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [TRACK_W-1:0]      track;
    logic                    new_track;
    logic                    found;
    logic [DIST_W-1:0]       ld;
    logic [DIST_W-1:0]       rd;
    logic signed [VEL_W-1:0] lv;
    logic signed [VEL_W-1:0] rv;
  } frame_t;

  typedef struct {
    logic [TRACK_W-1:0] track;
    maneuver_e          raw;
    maneuver_e          man;
  } verdict_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   s_tvalid;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // model state
  logic [DIST_W-1:0] lim_dist_mm;
  logic [DIST_W-1:0] lim_time_ms;
  logic [RUN_W-1:0]  run_need;
  logic [31:0]       slot_history [SLOTS];
  logic [CNT_W-1:0]  slot_frames [SLOTS];
  maneuver_e         slot_last [SLOTS];

  verdict_t    pending_verdicts [$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          settings_run = 0;
  int          hold_cycles = 0;
  bit          pace_on = 1'b1;
  int unsigned cycles = 0;

  lane_change_maneuver_debouncer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit closing_in(logic [DIST_W-1:0] d, logic [DIST_W-1:0] other,
                                    logic [VEL_W-1:0] v);
    logic [16:0] mag;
    logic [63:0] lhs;
    logic [63:0] rhs;
    if (!(d < other) || !(d < lim_dist_mm) || !v[VEL_W-1]) return 1'b0;
    mag = 17'h10000 - {1'b0, v};
    lhs = 64'(d) * 64'd1000;
    rhs = 64'(lim_time_ms) * 64'(mag);
    return lhs < rhs;
  endfunction

  function automatic verdict_t debounce_frame(frame_t f);
    verdict_t r;
    int       s;
    int       n;
    bit       agree;
    s = f.track;
    if (f.new_track) begin
      slot_history[s] = '0;
      slot_frames[s] = '0;
      slot_last[s] = MAN_FOLLOW;
    end
    if (slot_frames[s] < COUNT_MAX) slot_frames[s] = slot_frames[s] + 1'b1;
    r.track = f.track;
    r.raw = MAN_FOLLOW;
    if (slot_frames[s] >= 2 && f.found && (f.ld != 0 || f.rd != 0)) begin
      if (closing_in(f.ld, f.rd, f.lv)) r.raw = MAN_LEFT;
      else if (closing_in(f.rd, f.ld, f.rv)) r.raw = MAN_RIGHT;
    end
    slot_history[s] = {slot_history[s][29:0], r.raw};
    if (slot_frames[s] < 2) begin
      r.man = r.raw;
    end else begin
      n = run_need;
      if (n > slot_frames[s]) n = slot_frames[s];
      if (n > 16) n = 16;
      agree = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (slot_history[s][2*i +: 2] != r.raw) agree = 1'b0;
      end
      r.man = agree ? r.raw : slot_last[s];
    end
    slot_last[s] = r.man;
    return r;
  endfunction

  function automatic frame_t frame_of(logic [3:0] track, logic nt, logic found,
                                      logic [15:0] ld, logic [15:0] rd,
                                      logic [15:0] lv, logic [15:0] rv);
    frame_t f;
    f.track = track;
    f.new_track = nt;
    f.found = found;
    f.ld = ld;
    f.rd = rd;
    f.lv = lv;
    f.rv = rv;
    return f;
  endfunction

  // a frame drifting toward one bound, or wandering when the lean is follow
  function automatic frame_t drift_frame(logic [3:0] track, maneuver_e lean);
    frame_t f;
    int     near_d;
    int     far_d;
    int     spd;
    f.track = track;
    f.new_track = 1'b0;
    f.found = ($urandom_range(0, 15) != 0);
    f.lv = 16'($urandom);
    f.rv = 16'($urandom);
    near_d = $urandom_range(0, int'(lim_dist_mm) + 300);
    if (near_d > 65535) near_d = 65535;
    far_d = near_d + $urandom_range(0, 4000);
    if (far_d > 65535) far_d = 65535;
    spd = $urandom_range(0, 32768);
    case (lean)
      MAN_LEFT: begin
        f.ld = 16'(near_d);
        f.rd = 16'(far_d);
        f.lv = 16'(-spd);
      end
      MAN_RIGHT: begin
        f.rd = 16'(near_d);
        f.ld = 16'(far_d);
        f.rv = 16'(-spd);
      end
      default: begin
        f.ld = 16'($urandom);
        f.rd = 16'($urandom);
      end
    endcase
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    int gap;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata <= {4'b0, f.rv, f.lv, f.rd, f.ld, f.track};
    s_tuser <= {f.found, f.new_track};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_verdicts.push_back(debounce_frame(f));
    items_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_limits(logic [15:0] dist_mm, logic [15:0] tms, logic [4:0] run);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DIST;
    cfg_wdata <= dist_mm;
    @(posedge clk_i);
    cfg_addr <= REG_TIME;
    cfg_wdata <= tms;
    @(posedge clk_i);
    cfg_addr <= REG_RUN;
    cfg_wdata <= {11'b0, run};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    lim_dist_mm = dist_mm;
    lim_time_ms = tms;
    run_need = run;
    settings_run++;
  endtask

  task automatic run_traffic(int items);
    int        remaining;
    int        run_n;
    logic [3:0] trk;
    maneuver_e lean;
    frame_t    f;
    remaining = items;
    while (remaining > 0) begin
      if ($urandom_range(0, 29) == 0) pace_on = ~pace_on;
      if ($urandom_range(0, 9) == 0) begin
        f = frame_of(4'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
        send_frame(f);
        remaining--;
      end else begin
        trk = 4'($urandom);
        lean = maneuver_e'($urandom_range(0, 2));
        run_n = $urandom_range(1, 18);
        for (int k = 0; k < run_n && remaining > 0; k++) begin
          f = drift_frame(trk, lean);
          f.new_track = (k == 0) && ($urandom_range(0, 5) == 0);
          send_frame(f);
          remaining--;
        end
      end
    end
    pace_on = 1'b1;
  endtask

  // first frame, no lane, zero-width lane and equal distances all give follow
  task automatic test_follow_gates();
    send_frame(frame_of(4'd0, 1'b1, 1'b1, 16'd100, 16'd2000, -16'sd500, 16'sd0));
    send_frame(frame_of(4'd0, 1'b0, 1'b0, 16'd100, 16'd2000, -16'sd500, 16'sd0));
    send_frame(frame_of(4'd0, 1'b0, 1'b1, 16'd0, 16'd0, -16'sd500, -16'sd500));
    send_frame(frame_of(4'd0, 1'b0, 1'b1, 16'd300, 16'd300, -16'sd2000, -16'sd2000));
  endtask

  // output switches only once the run of agreeing guesses is long enough
  task automatic test_debounce_runs();
    send_frame(frame_of(4'd1, 1'b1, 1'b1, 16'd200, 16'd3000, -16'sd1000, 16'sd0));
    repeat (4) send_frame(frame_of(4'd1, 1'b0, 1'b1, 16'd200, 16'd3000, -16'sd1000, 16'sd0));
    repeat (3) send_frame(frame_of(4'd1, 1'b0, 1'b1, 16'd4000, 16'd100, 16'sd0, -16'sh8000));
    send_frame(frame_of(4'd15, 1'b1, 1'b1, 16'd4000, 16'd100, 16'sd0, -16'sh8000));
    send_frame(frame_of(4'd1, 1'b1, 1'b1, 16'd4000, 16'd100, 16'sd0, -16'sh8000));
  endtask

  // time and distance edges, extreme velocities and distances
  task automatic test_limits_edges();
    send_frame(frame_of(4'd2, 1'b1, 1'b1, 16'd5, 16'd900, -16'sd1, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd5, 16'd900, -16'sd1, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd4, 16'd900, -16'sd1, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd999, 16'd65535, -16'sh8000, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd1000, 16'd65535, -16'sh8000, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd10, 16'd900, 16'sd32767, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd10, 16'd900, 16'sd0, 16'sd0));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd1, 16'd0, 16'sd0, -16'sd1));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd0, 16'd65535, -16'sh8000, 16'sd32767));
    send_frame(frame_of(4'd2, 1'b0, 1'b1, 16'd65535, 16'd0, 16'sd32767, -16'sh8000));
  endtask

  task automatic test_register_sweep();
    logic [15:0] dists [6] = '{16'd0, 16'd65535, 16'd65535, 16'd2500, 16'd0, 16'd0};
    logic [15:0] times [6] = '{16'd65535, 16'd0, 16'd65535, 16'd20000, 16'd0, 16'd0};
    logic [4:0]  runs [6]  = '{5'd1, 5'd16, 5'd16, 5'd2, 5'd0, 5'd0};
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p >= 4) load_limits(16'($urandom_range(0, 4000)), 16'($urandom),
                              5'($urandom_range(1, 16)));
      else load_limits(dists[p], times[p], runs[p]);
      run_traffic(290);
    end
    settle();
    load_limits(DIST_RST, TIME_RST, RUN_RST);
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_output_stall();
    settle();
    pace_on = 1'b0;
    hold_cycles = 80;
    for (int k = 0; k < 12; k++) send_frame(drift_frame(4'(k % 3), MAN_LEFT));
    pace_on = 1'b1;
  endtask

  // sender waits for all results of a first batch before sending a second
  task automatic test_sender_pause();
    for (int k = 0; k < 8; k++) send_frame(drift_frame(4'd7, MAN_RIGHT));
    settle();
    for (int k = 0; k < 8; k++) send_frame(drift_frame(4'd7, MAN_RIGHT));
  endtask

  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = pace_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o && hold_cycles == 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= 20) $display("%0t: unexpected result %h", $time, m_axis_tdata_o);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata_o[3:0] !== want.track || m_axis_tdata_o[5:4] !== want.raw ||
            m_axis_tdata_o[7:6] !== want.man) begin
          errors++;
          if (errors <= 20)
            $display("%0t: mismatch expected trk %0d raw %0d man %0d, got trk %0d raw %0d man %0d",
                     $time, want.track, want.raw, want.man, m_axis_tdata_o[3:0],
                     m_axis_tdata_o[5:4], m_axis_tdata_o[7:6]);
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_DIST;
    cfg_wdata <= '0;
    lim_dist_mm = DIST_RST;
    lim_time_ms = TIME_RST;
    run_need = RUN_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_history[i] = '0;
      slot_frames[i] = '0;
      slot_last[i] = MAN_FOLLOW;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_follow_gates();
    test_debounce_runs();
    test_limits_edges();
    test_register_sweep();
    test_output_stall();
    test_sender_pause();
    settle();
    repeat (10) @(posedge clk_i);
    $display("frames sent %0d, results checked %0d, threshold settings %0d",
             items_sent, results_seen, settings_run);
    $display("covered follow gates, debounce runs, time edges, stalls; %0d errors", errors);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/lcmd_pkg.sv
rtl/core/lcmd_ctrl.sv
rtl/core/lcmd_dpath.sv
rtl/core/lane_change_maneuver_debouncer_top.sv
tb/lane_change_maneuver_debouncer_top_test.sv
